>>> rtl/single_source_shortest_paths_top_macros.svh
// assertion macros shared by the shortest path checker
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_TOP_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define SSSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// property that must also hold while reset is applied
`define SSSP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/sssp_pkg.sv
// shared constants, types and helpers for the shortest path block
`timescale 1ns / 1ps

package sssp_pkg;

  localparam int MAX_NODES = 16;
  localparam int NODE_W    = 4;
  localparam int COST_W    = 14;
  localparam int CNT_W     = 5;
  localparam int ADDR_W    = 2 * NODE_W;

  localparam logic [COST_W-1:0] NO_PATH_COST     = 14'd9999;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RESET = 5'd16;

  // action codes of an input transaction
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [CNT_W-1:0]  count_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic  load_wr;
    logic  start;
    logic  init_rd;
    logic  relax_rd;
    logic  scan_en;
    logic  scan_first;
    logic  pick_en;
    logic  out_load;
    logic  out_last;
    node_t idx;
  } sssp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    node_t n_last;
    node_t src;
    logic  src_ok;
    logic  found;
    logic  out_free;
  } sssp_stat_t;

  // zero and oversized weights mean no edge
  function automatic cost_t edge_cost(cost_t w);
    if (w == '0 || w >= NO_PATH_COST) begin
      return NO_PATH_COST;
    end
    return w;
  endfunction

  // highest node index in use, node count clamped to 2..MAX_NODES
  function automatic node_t last_node(count_t cnt);
    if (cnt < count_t'(2)) begin
      return node_t'(1);
    end
    if (cnt > count_t'(MAX_NODES)) begin
      return node_t'(MAX_NODES - 1);
    end
    return node_t'(cnt - count_t'(1));
  endfunction

endpackage

>>> rtl/sssp_if.sv
// valid/ready channel interfaces for input and result transactions
`timescale 1ns / 1ps

interface sssp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [sssp_pkg::NODE_W-1:0]  edge_row;
  logic [sssp_pkg::NODE_W-1:0]  edge_col;
  logic [sssp_pkg::COST_W-1:0]  edge_weight;
  logic [sssp_pkg::NODE_W-1:0]  source_node;

  modport source (output valid, action, edge_row, edge_col, edge_weight, source_node,
                  input ready);
  modport sink (input valid, action, edge_row, edge_col, edge_weight, source_node,
                output ready);
endinterface

interface sssp_out_if;
  logic                         valid;
  logic                         ready;
  logic [sssp_pkg::NODE_W-1:0]  node_index;
  logic [sssp_pkg::COST_W-1:0]  path_cost;
  logic [sssp_pkg::NODE_W-1:0]  predecessor;
  logic                         reachable;
  logic                         last;

  modport source (output valid, node_index, path_cost, predecessor, reachable, last,
                  input ready);
  modport sink (input valid, node_index, path_cost, predecessor, reachable, last,
                output ready);
endinterface

>>> rtl/single_source_shortest_paths_top.sv
// top level of the dense-matrix shortest path engine
//
// Input channel in_ch carries two kinds of transaction. A load (action 0)
// writes one edge weight into the 16x16 weight memory and is taken with no
// result. A run (action 1) names the source node; the engine then computes
// shortest distances to every node in use and sends one result transaction
// per node other than the source on out_ch, in ascending node order, with
// last set on the final one. A run whose source is not below the node count
// gives no results.
// cfg_we/cfg_wdata write the node count register (reset 16, clamped to 2..16).
// A run has an initialisation pass over the nodes in use, then per visited
// node a minimum scan, a pick step, a relaxation pass and a settle step,
// and then the result pass, one result per node in use but the source. Its
// length is set by the single read port of the weight memory and the
// one-node-per-cycle scan.
// in_ch is ready only while the engine is idle; a run ends when its last
// result is in the output register, so the next transaction can be taken
// while it waits.
// A stalled receiver holds the result register and pauses result emission.
// Reset (rst, synchronous) returns to idle, empties the output and sets the
// node count to 16; the weight memory keeps whatever it held.
`timescale 1ns / 1ps

module single_source_shortest_paths_top (
  input  logic                        clk,
  input  logic                        rst,
  sssp_in_if.sink                     in_ch,
  sssp_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [sssp_pkg::CNT_W-1:0]  cfg_wdata
);

  sssp_pkg::sssp_cmd_t  cmd;
  sssp_pkg::sssp_stat_t stat;

  // sequencer
  sssp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .stat      (stat),
    .cmd       (cmd)
  );

  // storage and arithmetic
  sssp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .edge_row    (in_ch.edge_row),
    .edge_col    (in_ch.edge_col),
    .edge_weight (in_ch.edge_weight),
    .source_node (in_ch.source_node),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .node_index  (out_ch.node_index),
    .path_cost   (out_ch.path_cost),
    .predecessor (out_ch.predecessor),
    .reachable   (out_ch.reachable),
    .last        (out_ch.last)
  );

endmodule

>>> rtl/sssp_datapath.sv
// weight memory, distance tables, minimum scan and result register
`timescale 1ns / 1ps

module sssp_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sssp_pkg::sssp_cmd_t           cmd,
  output sssp_pkg::sssp_stat_t          stat,
  input  logic                          cfg_we,
  input  logic [sssp_pkg::CNT_W-1:0]    cfg_wdata,
  input  logic [sssp_pkg::NODE_W-1:0]   edge_row,
  input  logic [sssp_pkg::NODE_W-1:0]   edge_col,
  input  logic [sssp_pkg::COST_W-1:0]   edge_weight,
  input  logic [sssp_pkg::NODE_W-1:0]   source_node,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sssp_pkg::NODE_W-1:0]   node_index,
  output logic [sssp_pkg::COST_W-1:0]   path_cost,
  output logic [sssp_pkg::NODE_W-1:0]   predecessor,
  output logic                          reachable,
  output logic                          last
);

  logic [sssp_pkg::COST_W-1:0] weight_mem [2**sssp_pkg::ADDR_W];
  logic [sssp_pkg::COST_W-1:0] rd_data;
  logic [sssp_pkg::ADDR_W-1:0] rd_addr;

  sssp_pkg::cost_t  best [sssp_pkg::MAX_NODES];
  sssp_pkg::node_t  prev [sssp_pkg::MAX_NODES];
  logic [sssp_pkg::MAX_NODES-1:0] done;

  sssp_pkg::count_t node_count;
  sssp_pkg::node_t  n_last;
  sssp_pkg::node_t  src;
  sssp_pkg::node_t  pick;
  sssp_pkg::cost_t  mind;
  logic             found;

  logic             pend_init;
  logic             pend_relax;
  sssp_pkg::node_t  idx_d;

  sssp_pkg::node_t  tab_addr;
  sssp_pkg::cost_t  tab_best;
  logic             tab_done;
  sssp_pkg::cost_t  wcost;
  logic [sssp_pkg::COST_W:0] relax_sum;
  sssp_pkg::cost_t  scan_limit;
  logic             scan_hit;

  // node count register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= sssp_pkg::NODE_COUNT_RESET;
    end else if (cfg_we) begin
      node_count <= cfg_wdata;
    end
  end

  assign n_last = sssp_pkg::last_node(node_count);

  // weight memory, one write and one registered read port
  assign rd_addr = {(cmd.init_rd ? src : pick), cmd.idx};

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      weight_mem[{edge_row, edge_col}] <= edge_weight;
    end
    rd_data <= weight_mem[rd_addr];
  end

  // pending read bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_init  <= 1'b0;
      pend_relax <= 1'b0;
    end else begin
      pend_init  <= cmd.init_rd;
      pend_relax <= cmd.relax_rd;
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= cmd.idx;
  end

  // single read port of the distance and visited tables, shared by apply and scan/output
  assign tab_addr  = (pend_init || pend_relax) ? idx_d : cmd.idx;
  assign tab_best  = best[tab_addr];
  assign tab_done  = done[tab_addr];
  assign wcost     = sssp_pkg::edge_cost(rd_data);
  assign relax_sum = {1'b0, mind} + {1'b0, wcost};

  // run source capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      src <= source_node;
    end
  end

  // distance and predecessor updates
  always_ff @(posedge clk) begin
    if (pend_init) begin
      best[idx_d] <= (idx_d == src) ? '0 : wcost;
      prev[idx_d] <= src;
    end else if (pend_relax && !tab_done && relax_sum < {1'b0, tab_best}) begin
      best[idx_d] <= relax_sum[sssp_pkg::COST_W-1:0];
      prev[idx_d] <= pick;
    end
  end

  // visited marks
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (pend_init) begin
      done[idx_d] <= (idx_d == src);
    end else if (cmd.pick_en) begin
      done[pick] <= 1'b1;
    end
  end

  // nearest unvisited node scan, lowest index wins ties
  assign scan_limit = cmd.scan_first ? sssp_pkg::NO_PATH_COST : mind;
  assign scan_hit   = !tab_done && (tab_best < scan_limit);

  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      if (scan_hit) begin
        mind  <= tab_best;
        pick  <= cmd.idx;
        found <= 1'b1;
      end else if (cmd.scan_first) begin
        mind  <= sssp_pkg::NO_PATH_COST;
        pick  <= '0;
        found <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      node_index  <= cmd.idx;
      path_cost   <= tab_best;
      predecessor <= prev[cmd.idx];
      reachable   <= (tab_best < sssp_pkg::NO_PATH_COST);
      last        <= cmd.out_last;
    end
  end

  // status to the controller
  always_comb begin
    stat          = '0;
    stat.n_last   = n_last;
    stat.src      = src;
    stat.src_ok   = (source_node <= n_last);
    stat.found    = found;
    stat.out_free = !out_valid || out_ready;
  end

endmodule

>>> rtl/sssp_ctrl.sv
// run sequencer: initialise, scan, relax and result emission
`timescale 1ns / 1ps

module sssp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  sssp_pkg::sssp_stat_t  stat,
  output sssp_pkg::sssp_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INIT   = 3'd1;
  localparam logic [2:0] S_SETTLE = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_RELAX  = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]       state, state_next;
  sssp_pkg::node_t  idx, idx_next;
  sssp_pkg::count_t round, round_next;
  logic             at_end;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      round <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      round <= round_next;
    end
  end

  assign at_end   = (idx == stat.n_last);
  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next = state;
    idx_next   = idx;
    round_next = round;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_action == sssp_pkg::ACT_LOAD) begin
            cmd.load_wr = 1'b1;
          end else if (stat.src_ok) begin
            cmd.start  = 1'b1;
            state_next = S_INIT;
            idx_next   = '0;
            round_next = sssp_pkg::count_t'(1);
          end
        end
      end
      S_INIT: begin
        cmd.init_rd = 1'b1;
        if (at_end) begin
          state_next = S_SETTLE;
        end else begin
          idx_next = idx + sssp_pkg::node_t'(1);
        end
      end
      S_SETTLE: begin
        idx_next = '0;
        if (round <= {1'b0, stat.n_last}) begin
          state_next = S_SCAN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_en    = 1'b1;
        cmd.scan_first = (idx == '0);
        if (at_end) begin
          state_next = S_PICK;
        end else begin
          idx_next = idx + sssp_pkg::node_t'(1);
        end
      end
      S_PICK: begin
        idx_next = '0;
        if (stat.found) begin
          cmd.pick_en = 1'b1;
          round_next  = round + sssp_pkg::count_t'(1);
          state_next  = S_RELAX;
        end else begin
          state_next = S_OUT;
        end
      end
      S_RELAX: begin
        cmd.relax_rd = 1'b1;
        if (at_end) begin
          state_next = S_SETTLE;
        end else begin
          idx_next = idx + sssp_pkg::node_t'(1);
        end
      end
      S_OUT: begin
        // the source node gives no result and is stepped over
        if (idx == stat.src || stat.out_free) begin
          cmd.out_load = (idx != stat.src);
          cmd.out_last = at_end ||
                         ((idx + sssp_pkg::node_t'(1)) == stat.n_last &&
                          stat.src == stat.n_last);
          if (at_end) begin
            state_next = S_IDLE;
          end else begin
            idx_next = idx + sssp_pkg::node_t'(1);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/sssp_checker.sv
// port-level checks on the shortest path engine, bound to the top level
`timescale 1ns / 1ps
`include "single_source_shortest_paths_top_macros.svh"

module sssp_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_ready,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [sssp_pkg::NODE_W-1:0] node_index,
  input  logic [sssp_pkg::COST_W-1:0] path_cost,
  input  logic [sssp_pkg::NODE_W-1:0] predecessor,
  input  logic                        reachable,
  input  logic                        last
);

  // reset empties the result register
  `SSSP_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "result valid after reset")

  // a stalled result transaction holds
  `SSSP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({node_index, path_cost, predecessor, reachable, last}), "stalled result changed")

  // no new input while a run still has results to send
  `SSSP_ASSERT(a_busy_in_run, out_valid && !last |-> !in_ready, "input taken mid-run")

  // reachable flag agrees with the distance
  `SSSP_ASSERT(a_reach_cost, out_valid |-> (reachable == (path_cost != sssp_pkg::NO_PATH_COST)), "reachable flag mismatch")

endmodule

bind single_source_shortest_paths_top sssp_checker u_sssp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .node_index  (out_ch.node_index),
  .path_cost   (out_ch.path_cost),
  .predecessor (out_ch.predecessor),
  .reachable   (out_ch.reachable),
  .last        (out_ch.last)
);
